### sv/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg
// Shared types and constants of the Huffman tree builder.
// ----------------------------------------------------------------------------
package htb_pkg;
	localparam int unsigned SYMBOLS_DEF = 256;
	localparam int unsigned ID_W        = 9;
	localparam int unsigned FREQ_W      = 32;
	localparam int unsigned IN_FREQ_W   = 24;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_MERGE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_MERGED = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;

	localparam logic [ID_W-1:0] FIRST_INT = 9'd256;
	localparam logic [ID_W-1:0] LAST_INT  = 9'd510;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [FREQ_W-1:0] freq;
	} entry_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   left_node;
		logic [ID_W-1:0]   right_node;
		logic [ID_W-1:0]   parent_node;
		logic [FREQ_W-1:0] parent_freq;
	} result_t;
endpackage

### sv/htb_ram.sv
// ----------------------------------------------------------------------------
// htb_ram
// Heap entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module htb_ram #(
	parameter int unsigned DEPTH = htb_pkg::SYMBOLS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  htb_pkg::entry_t       wdata,
	input  logic [AW-1:0]         raddr,
	output htb_pkg::entry_t       rdata
);
	import htb_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/huffman_tree_builder.sv
// Load: the new entry sifts up the heap, one level per read and compare step.
// Merge: each of the two extractions takes the root, moves the last entry to the
// root and sifts it down one level per step; the result is then made valid and the
// new internal node is inserted by a sift-up before the next transfer is taken.
// Clear and skipped items return straight to idle; one item at a time (single read port).
// Reset (arst_n, asynchronous): heap empty, next internal id 256; no clearing pass.
// ----------------------------------------------------------------------------
// huffman_tree_builder
// Min-heap Huffman tree builder over a single synchronous heap memory.
// ----------------------------------------------------------------------------
module huffman_tree_builder #(
	parameter int unsigned SYMBOLS = htb_pkg::SYMBOLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // symbol[7:0], frequency[31:8]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // left[8:0] right[17:9] parent[26:18] freq[58:27]
	output logic [1:0]  m_tuser    // status[1:0]
);
	import htb_pkg::*;

	localparam int unsigned AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] CAP = CW'(SYMBOLS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_UPRD  = 4'd1;
	localparam logic [3:0] S_UPCK  = 4'd2;
	localparam logic [3:0] S_X0RD  = 4'd3;
	localparam logic [3:0] S_X0CK  = 4'd4;
	localparam logic [3:0] S_LAST  = 4'd5;
	localparam logic [3:0] S_DNL   = 4'd6;
	localparam logic [3:0] S_DNR   = 4'd7;
	localparam logic [3:0] S_DNCK  = 4'd8;
	localparam logic [3:0] S_SUM   = 4'd9;
	localparam logic [3:0] S_ONE   = 4'd10;

	logic [3:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [ID_W-1:0] next_id_q;
	logic [AW-1:0]   pos_q;
	entry_t          item_q;
	entry_t          lchild_q;
	entry_t          first_q;
	entry_t          right_q;
	logic            second_q;
	logic            out_valid_q;
	result_t         res_q;
	logic            byp_q;
	entry_t          byp_data_q;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	entry_t          wdata, rdata, rd;

	htb_ram #(.DEPTH(SYMBOLS), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic          acc;
	logic [CW-1:0] lidx, ridx;
	logic [AW-1:0] parent;
	logic [FREQ_W:0] sum_w;
	logic            l_ok, r_ok;
	logic            pick_l, pick_r;

	// write-to-read bypass for the same entry at the same edge
	assign rd       = byp_q ? byp_data_q : rdata;
	assign s_tready = (state_q == S_IDLE) && !out_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign lidx     = {pos_q, 1'b1};
	assign ridx     = CW'({pos_q, 1'b0}) + CW'(2);
	assign parent   = AW'((CW'(pos_q) - CW'(1)) >> 1);
	assign sum_w    = {1'b0, first_q.freq} + {1'b0, right_q.freq};
	assign l_ok     = lidx < count_q;
	assign r_ok     = ridx < count_q;
	assign pick_l   = l_ok && (lchild_q.freq < item_q.freq);
	assign pick_r   = r_ok && (rd.freq < (pick_l ? lchild_q.freq : item_q.freq));

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = item_q;
		raddr = '0;
		case (state_q)
			S_IDLE: raddr = '0;
			S_UPRD: raddr = parent;
			S_UPCK: begin
				if (pos_q != '0 && item_q.freq < rd.freq) begin
					we = 1'b1; wdata = rd;
				end else begin
					we = 1'b1;
				end
				raddr = parent;
			end
			S_X0RD: raddr = AW'(count_q - CW'(1));
			S_X0CK: raddr = AW'(count_q - CW'(1));
			S_LAST: raddr = AW'(lidx);
			S_DNL:  raddr = AW'(ridx);
			S_DNCK: begin
				we = 1'b1;
				if (pick_r) begin
					wdata = rd;
				end else if (pick_l) begin
					wdata = lchild_q;
				end
				raddr = pick_r ? AW'({ridx, 1'b1}) : (pick_l ? AW'({lidx, 1'b1}) : '0);
			end
			default: ;
		endcase
		if (state_q == S_DNR) begin
			raddr = AW'(ridx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			next_id_q   <= FIRST_INT;
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (acc) begin
					case (s_tuser)
						ACT_LOAD: if (s_tdata[31:8] != '0 && count_q < CAP) begin
							item_q  <= '{id: ID_W'(s_tdata[7:0]), freq: FREQ_W'(s_tdata[31:8])};
							pos_q   <= AW'(count_q);
							count_q <= count_q + CW'(1);
							state_q <= S_UPRD;
						end
						ACT_CLEAR: begin
							count_q   <= '0;
							next_id_q <= FIRST_INT;
						end
						ACT_MERGE: begin
							if (count_q == '0) begin
								res_q       <= '{ST_EMPTY, '0, '0, '0, '0};
								out_valid_q <= 1'b1;
							end else if (count_q == CW'(1)) begin
								state_q <= S_ONE;
							end else begin
								second_q <= 1'b0;
								state_q  <= S_X0RD;
							end
						end
						default: ;
					endcase
				end
				S_ONE: begin
					res_q       <= '{ST_DONE, '0, '0, rd.id, rd.freq};
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_UPRD: state_q <= S_UPCK;
				S_UPCK: begin
					if (pos_q != '0 && item_q.freq < rd.freq) begin
						pos_q   <= parent;
						state_q <= S_UPRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_X0RD: begin
					if (!second_q) first_q <= rd; else right_q <= rd;
					state_q <= S_X0CK;
				end
				S_X0CK: begin
					count_q <= count_q - CW'(1);
					pos_q   <= '0;
					state_q <= S_LAST;
				end
				S_LAST: begin
					item_q  <= rd;
					state_q <= S_DNL;
				end
				S_DNL: begin
					lchild_q <= rd;
					state_q  <= S_DNR;
				end
				S_DNR: state_q <= S_DNCK;
				S_DNCK: begin
					if (pick_r) begin
						pos_q <= AW'(ridx);
						state_q <= S_DNL;
					end else if (pick_l) begin
						pos_q <= AW'(lidx);
						state_q <= S_DNL;
					end else if (!second_q) begin
						second_q <= 1'b1;
						state_q  <= S_X0RD;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					res_q.status      <= ST_MERGED;
					res_q.left_node   <= first_q.id;
					res_q.right_node  <= right_q.id;
					res_q.parent_node <= next_id_q;
					res_q.parent_freq <= sum_w[FREQ_W] ? '1 : sum_w[FREQ_W-1:0];
					item_q.id   <= next_id_q;
					item_q.freq <= sum_w[FREQ_W] ? '1 : sum_w[FREQ_W-1:0];
					next_id_q   <= (next_id_q >= LAST_INT) ? FIRST_INT : next_id_q + ID_W'(1);
					pos_q       <= AW'(count_q);
					count_q     <= count_q + CW'(1);
					out_valid_q <= 1'b1;
					state_q     <= S_UPRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {5'd0, res_q.parent_freq, res_q.parent_node,
		res_q.right_node, res_q.left_node};

`ifndef SYNTHESIS
	a_count: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CAP)
		else $error("heap count over capacity");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
	a_id: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q >= FIRST_INT && next_id_q <= LAST_INT)
		else $error("internal id out of range");
`endif
endmodule

### verif/tb_huffman_tree_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_builder
// Drives load, merge, clear and unused-code transfers into the tree builder and checks
// every merge result against a min-heap predictor kept in the testbench.
// ----------------------------------------------------------------------------
class merge_scoreboard;
	logic [8:0]  hid [256];
	logic [31:0] hfrq [256];
	int unsigned cnt;
	logic [8:0]  next_id;
	htb_pkg::result_t pending [$];
	int errors;

	function void clear_heap();
		cnt = 0;
		next_id = htb_pkg::FIRST_INT;
	endfunction

	function void push_node(logic [8:0] id, logic [31:0] f);
		int unsigned p;
		int unsigned up;
		if (cnt >= 256)
			return;
		p = cnt;
		cnt++;
		while (p > 0) begin
			up = (p - 1) / 2;
			if (!(f < hfrq[up]))
				break;
			hid[p] = hid[up];
			hfrq[p] = hfrq[up];
			p = up;
		end
		hid[p] = id;
		hfrq[p] = f;
	endfunction

	function void pop_min(output logic [8:0] id, output logic [31:0] f);
		int unsigned p;
		int unsigned m;
		logic [8:0]  ti;
		logic [31:0] tf;
		id = hid[0];
		f = hfrq[0];
		cnt--;
		hid[0] = hid[cnt];
		hfrq[0] = hfrq[cnt];
		p = 0;
		forever begin
			m = p;
			if (2 * p + 1 < cnt && hfrq[2 * p + 1] < hfrq[m])
				m = 2 * p + 1;
			if (2 * p + 2 < cnt && hfrq[2 * p + 2] < hfrq[m])
				m = 2 * p + 2;
			if (m == p)
				break;
			ti = hid[m]; tf = hfrq[m];
			hid[m] = hid[p]; hfrq[m] = hfrq[p];
			hid[p] = ti; hfrq[p] = tf;
			p = m;
		end
	endfunction

	function void note_input(logic [1:0] act, logic [7:0] sym, logic [23:0] f);
		htb_pkg::result_t r;
		logic [31:0] lf;
		logic [31:0] rf;
		logic [32:0] s;
		r = '0;
		case (act)
			htb_pkg::ACT_LOAD: begin
				if (f != 0)
					push_node({1'b0, sym}, {8'd0, f});
			end
			htb_pkg::ACT_CLEAR: clear_heap();
			htb_pkg::ACT_MERGE: begin
				if (cnt == 0) begin
					r.status = htb_pkg::ST_EMPTY;
				end else if (cnt == 1) begin
					r.status = htb_pkg::ST_DONE;
					r.parent_node = hid[0];
					r.parent_freq = hfrq[0];
				end else begin
					pop_min(r.left_node, lf);
					pop_min(r.right_node, rf);
					s = lf + rf;
					r.status = htb_pkg::ST_MERGED;
					r.parent_freq = s[32] ? 32'hFFFF_FFFF : s[31:0];
					r.parent_node = next_id;
					next_id = (next_id >= htb_pkg::LAST_INT) ? htb_pkg::FIRST_INT
						: next_id + 9'd1;
					push_node(r.parent_node, r.parent_freq);
				end
				pending.push_back(r);
			end
			default: ;
		endcase
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task check_result(logic [1:0] st, logic [63:0] d);
		htb_pkg::result_t e;
		if (pending.size() == 0) begin
			report("unexpected result", 32'd1, 32'd0);
			return;
		end
		e = pending.pop_front();
		if (st != e.status) report("status", 32'(st), 32'(e.status));
		if (d[8:0] != e.left_node) report("left", 32'(d[8:0]), 32'(e.left_node));
		if (d[17:9] != e.right_node) report("right", 32'(d[17:9]), 32'(e.right_node));
		if (d[26:18] != e.parent_node)
			report("parent", 32'(d[26:18]), 32'(e.parent_node));
		if (d[58:27] != e.parent_freq) report("freq", d[58:27], e.parent_freq);
	endtask
endclass

module tb_huffman_tree_builder;
	import htb_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	merge_scoreboard sb;
	bit          calm_tx;
	bit          calm_rx;
	bit          hold_rx;
	int unsigned cycles;

	huffman_tree_builder u_dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
		m_tready <= !hold_rx && (calm_rx || $urandom_range(99) >= 32);
	end

	task send(logic [1:0] act, logic [7:0] sym, logic [23:0] f);
		while (!calm_tx && $urandom_range(99) < 32) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= act;
		s_tdata <= {f, sym};
		do @(posedge clk); while (!s_tready);
		sb.note_input(act, sym, f);
	endtask

	task drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task build_tree(int n, bit big);
		int k;
		for (k = 0; k < n; k++)
			send(ACT_LOAD, 8'($urandom), 24'(big ? 32'hFFFFFF - $urandom_range(3)
				: ($urandom_range(9) == 0 ? 0 : $urandom_range(1, 1000))));
		for (k = 0; k < n + 1; k++)
			send(ACT_MERGE, 8'($urandom), 24'($urandom));
	endtask

	initial begin
		int i;
		int r;
		sb = new();
		sb.clear_heap();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty, single, skip, ties, unused code, clear
		send(ACT_MERGE, 0, 0);
		send(ACT_LOAD, 8'hFF, 24'hFFFFFF);
		send(ACT_MERGE, 0, 0);
		send(ACT_LOAD, 8'h00, 24'h0);
		send(ACT_LOAD, 8'h00, 24'hFFFFFF);
		send(ACT_LOAD, 8'h55, 24'h1);
		send(ACT_LOAD, 8'hAA, 24'h1);
		send(2'd3, 8'h12, 24'h5);
		send(ACT_MERGE, 0, 0);
		send(ACT_MERGE, 0, 0);
		send(ACT_MERGE, 0, 0);
		send(ACT_MERGE, 0, 0);
		send(ACT_CLEAR, 8'hFF, 24'hFFFFFF);
		send(ACT_MERGE, 0, 0);
		drain();
		// full heap, extra loads ignored, long merge chain wraps internal ids
		calm_tx = 1; calm_rx = 1;
		for (i = 0; i < 258; i++)
			send(ACT_LOAD, i[7:0], 24'($urandom_range(1, 3)));
		send(ACT_MERGE, 0, 0);
		fork
			begin
				hold_rx = 1;
				repeat (600) @(posedge clk);
				hold_rx = 0;
			end
			for (i = 0; i < 30; i++) send(ACT_MERGE, 0, 0);
		join
		calm_tx = 0; calm_rx = 0;
		for (i = 0; i < 230; i++) send(ACT_MERGE, 0, 0);
		drain();
		send(ACT_CLEAR, 0, 0);
		build_tree(20, 1);
		// random phase
		while (cycles < 1500000 && i < 1000) begin
			r = $urandom_range(99);
			if (r < 70) begin
				build_tree($urandom_range(1, 12), $urandom_range(9) == 0);
				i += 20;
			end else if (r < 80) begin
				send(ACT_CLEAR, 8'($urandom), 24'($urandom));
				i++;
			end else begin
				send(2'($urandom), 8'($urandom), 24'($urandom));
				i++;
			end
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### filelist.f
sv/htb_pkg.sv
sv/htb_ram.sv
sv/huffman_tree_builder.sv
verif/tb_huffman_tree_builder.sv
